// ----- rtl/core/lrr_pkg.sv -----
// Shared types, constants and the arctangent table of the line region rectangle block.
`default_nettype none
package lrr_pkg;

    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 33;
    localparam int NORM_STEPS = 6;

    localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
    localparam logic signed [32:0] LEVEL_LIMIT = 33'sd6;

    typedef enum logic [0:0] {
        REG_REGION_WIDTH = 1'b0,
        REG_LENGTH_RATIO = 1'b1
    } t_cfg_reg;

    // Geometry that rides along with the square root.
    typedef struct packed {
        logic               dx_zero;
        logic               dx_pos;
        logic               dy_nneg;
        logic               dy_zero;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        logic signed [57:0] rx;
        logic signed [57:0] ry;
        logic [32:0]        ux;
        logic [32:0]        uy;
    } t_geo;

    // What rides along with the normal divisions.
    typedef struct packed {
        logic               dx_zero;
        logic               dx_pos;
        logic               dy_nneg;
        logic               dy_zero;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        logic signed [57:0] rx;
        logic signed [57:0] ry;
        logic [31:0]        height;
    } t_mid;

    // Finished corners that ride along with the angle unit.
    typedef struct packed {
        logic [31:0] c0x;
        logic [31:0] c0y;
        logic [31:0] c1x;
        logic [31:0] c1y;
        logic [31:0] c2x;
        logic [31:0] c2y;
        logic [31:0] c3x;
        logic [31:0] c3y;
        logic [31:0] height;
        logic        level;
        logic        vert;
    } t_fin;

    // atan(2^-i) in Q2.30, truncated for indices 0 to 26 and rounded for 27 to 30.
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/line_region_rectangle.sv -----
// Line region rectangle: oriented rectangle corners, height and angle of a segment.
// Usage: an item on the input channel carries the two endpoints of a segment in
// signed Q16.16. One result item comes back per input item with the four corners,
// the region height and the angle of the short side. The configuration channel
// is always ready and writes the region width (index 0) or the length ratio
// (index 1); write it only while no item is in flight.
// Throughput is one item per cycle as long as the receiver takes each result: all
// stages form one chain (33 square root digits, 33 divider bits per lane, 6
// normalization steps, one arctangent rotation per iteration) and advance together.
// When the receiver stalls with a result waiting, the whole chain holds and the
// input ready drops in the same cycle; it rises as soon as the result is taken.
// Reset empties the chain and loads the width with 10.0 and the ratio with 1.0.
`default_nettype none
module line_region_rectangle import lrr_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_start_x,
    input  wire logic [31:0] i_start_y,
    input  wire logic [31:0] i_end_x,
    input  wire logic [31:0] i_end_y,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_corner0_x,
    output logic [31:0]      o_corner0_y,
    output logic [31:0]      o_corner1_x,
    output logic [31:0]      o_corner1_y,
    output logic [31:0]      o_corner2_x,
    output logic [31:0]      o_corner2_y,
    output logic [31:0]      o_corner3_x,
    output logic [31:0]      o_corner3_y,
    output logic [31:0]      o_region_height,
    output logic [17:0]      o_region_angle
);
    localparam int N      = ANGLE_ITERATIONS;
    localparam int DEPTH  = 81 + N;
    localparam int V_SQRT = 34;
    localparam int V_DIV  = 69;
    localparam int FIN_N  = 8 + N;

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        logic [31:0] r;
        if (v > 44'sd2147483647)       r = 32'h7FFFFFFF;
        else if (v < -44'sd2147483648) r = 32'h80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    // Configuration and valid chain
    logic [31:0]      r_width;
    logic [23:0]      r_ratio;
    logic [DEPTH-1:0] r_vld;
    logic             en;

    assign en          = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[DEPTH-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 32'd655360;
            r_ratio <= 24'd65536;
            r_vld   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_REGION_WIDTH: r_width <= i_cfg_data;
                    REG_LENGTH_RATIO: r_ratio <= i_cfg_data[23:0];
                endcase
            end
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
            end
        end
    end

    // Differences and sums
    logic signed [32:0] r_dx, r_dy, r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= $signed({i_start_x[31], i_start_x}) - $signed({i_end_x[31], i_end_x});
            r_dy <= $signed({i_start_y[31], i_start_y}) - $signed({i_end_y[31], i_end_y});
            r_sx <= $signed({i_start_x[31], i_start_x}) + $signed({i_end_x[31], i_end_x});
            r_sy <= $signed({i_start_y[31], i_start_y}) + $signed({i_end_y[31], i_end_y});
        end
    end

    // Squares and ratio products
    logic [32:0]        ux, uy;
    logic [65:0]        sq_a, sq_b;
    logic signed [57:0] rx, ry;
    logic [65:0]        r_rad;
    t_geo               r_geo [0:SQRT_STEPS];

    always_comb begin
        ux   = r_dx[32] ? 33'(-r_dx) : r_dx;
        uy   = r_dy[32] ? 33'(-r_dy) : r_dy;
        sq_a = ux * ux;
        sq_b = uy * uy;
        rx   = r_dx * $signed({1'b0, r_ratio});
        ry   = r_dy * $signed({1'b0, r_ratio});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad              <= sq_a + sq_b;
            r_geo[0].dx_zero   <= (r_dx == '0);
            r_geo[0].dx_pos    <= !r_dx[32] && (r_dx != '0);
            r_geo[0].dy_nneg   <= !r_dy[32];
            r_geo[0].dy_zero   <= (r_dy == '0);
            r_geo[0].sx        <= r_sx;
            r_geo[0].sy        <= r_sy;
            r_geo[0].rx        <= rx;
            r_geo[0].ry        <= ry;
            r_geo[0].ux        <= ux;
            r_geo[0].uy        <= uy;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                r_geo[k] <= r_geo[k-1];
            end
        end
    end

    // Square root chain
    logic [65:0] s_rad  [0:SQRT_STEPS];
    logic [35:0] s_rem  [0:SQRT_STEPS];
    logic [32:0] s_root [0:SQRT_STEPS];

    assign s_rad[0]  = r_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        lrr_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (s_rad[g]),
            .i_rem  (s_rem[g]),
            .i_root (s_root[g]),
            .o_rad  (s_rad[g+1]),
            .o_rem  (s_rem[g+1]),
            .o_root (s_root[g+1])
        );
    end

    // Rounded length and width products
    logic [33:0] len;
    logic [33:0] r_len;
    logic [64:0] r_uyw, r_uxw;
    t_geo        r_rgeo;

    assign len = {1'b0, s_root[SQRT_STEPS]}
               + 34'(s_rem[SQRT_STEPS] > {3'b000, s_root[SQRT_STEPS]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len  <= len;
            r_uyw  <= r_geo[SQRT_STEPS].uy * r_width;
            r_uxw  <= r_geo[SQRT_STEPS].ux * r_width;
            r_rgeo <= r_geo[SQRT_STEPS];
        end
    end

    // Dividends, divisor and height
    logic [65:0] num_x, num_y;
    logic [34:0] divisor;
    logic [57:0] hprod;
    logic [58:0] hsum;
    logic [42:0] hq;
    logic [32:0] r_num_x, r_num_y;
    logic [35:0] r_rem_x, r_rem_y;
    logic [34:0] r_div;
    t_mid        r_mid [0:DIV_STEPS];

    always_comb begin
        num_x   = 66'(r_uyw) + 66'(r_len);
        num_y   = 66'(r_uxw) + 66'(r_len);
        divisor = (r_len == '0) ? 35'd1 : {r_len, 1'b0};
        hprod   = r_len * r_ratio;
        hsum    = 59'(hprod) + 59'd32768;
        hq      = hsum[58:16];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x          <= num_x[32:0];
            r_num_y          <= num_y[32:0];
            r_rem_x          <= {3'b000, num_x[65:33]};
            r_rem_y          <= {3'b000, num_y[65:33]};
            r_div            <= divisor;
            r_mid[0].dx_zero <= r_rgeo.dx_zero;
            r_mid[0].dx_pos  <= r_rgeo.dx_pos;
            r_mid[0].dy_nneg <= r_rgeo.dy_nneg;
            r_mid[0].dy_zero <= r_rgeo.dy_zero;
            r_mid[0].sx      <= r_rgeo.sx;
            r_mid[0].sy      <= r_rgeo.sy;
            r_mid[0].rx      <= r_rgeo.rx;
            r_mid[0].ry      <= r_rgeo.ry;
            r_mid[0].height  <= (hq[42:32] != '0) ? 32'hFFFFFFFF : hq[31:0];
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    // Divider chains, one lane per normal component
    logic [32:0] s_dnum_x [0:DIV_STEPS];
    logic [35:0] s_drem_x [0:DIV_STEPS];
    logic [34:0] s_ddiv_x [0:DIV_STEPS];
    logic [32:0] s_dquo_x [0:DIV_STEPS];
    logic [32:0] s_dnum_y [0:DIV_STEPS];
    logic [35:0] s_drem_y [0:DIV_STEPS];
    logic [34:0] s_ddiv_y [0:DIV_STEPS];
    logic [32:0] s_dquo_y [0:DIV_STEPS];

    assign s_dnum_x[0] = r_num_x;
    assign s_drem_x[0] = r_rem_x;
    assign s_ddiv_x[0] = r_div;
    assign s_dquo_x[0] = '0;
    assign s_dnum_y[0] = r_num_y;
    assign s_drem_y[0] = r_rem_y;
    assign s_ddiv_y[0] = r_div;
    assign s_dquo_y[0] = '0;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        lrr_div_cell u_cell_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (s_dnum_x[g]),
            .i_rem (s_drem_x[g]),
            .i_div (s_ddiv_x[g]),
            .i_quo (s_dquo_x[g]),
            .o_num (s_dnum_x[g+1]),
            .o_rem (s_drem_x[g+1]),
            .o_div (s_ddiv_x[g+1]),
            .o_quo (s_dquo_x[g+1])
        );
        lrr_div_cell u_cell_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (s_dnum_y[g]),
            .i_rem (s_drem_y[g]),
            .i_div (s_ddiv_y[g]),
            .i_quo (s_dquo_y[g]),
            .o_num (s_dnum_y[g+1]),
            .o_rem (s_drem_y[g+1]),
            .o_div (s_ddiv_y[g+1]),
            .o_quo (s_dquo_y[g+1])
        );
    end

    // Scaled endpoints and normal offset
    t_mid               md;
    logic signed [59:0] base_x, base_y;
    logic signed [59:0] t1x, t1y, t2x, t2y;
    logic signed [33:0] px, off_x, off_y;
    logic signed [42:0] r_p1x, r_p1y, r_p2x, r_p2y;
    logic signed [33:0] r_offx, r_offy;
    logic [31:0]        r_o_height;

    always_comb begin
        md     = r_mid[DIV_STEPS];
        base_x = $signed({md.sx, 16'h0000}) + 60'sd65536;
        base_y = $signed({md.sy, 16'h0000}) + 60'sd65536;
        t1x    = base_x + md.rx;
        t1y    = base_y + md.ry;
        t2x    = base_x - md.rx;
        t2y    = base_y - md.ry;
        px     = $signed({1'b0, s_dquo_x[DIV_STEPS]});
        if (md.dx_zero) begin
            off_x = $signed({2'b00, 32'((33'(r_width) + 33'd1) >> 1)});
            off_y = '0;
        end else begin
            off_x = ((md.dx_pos == md.dy_nneg) || md.dy_zero) ? px : -px;
            off_y = -$signed({1'b0, s_dquo_y[DIV_STEPS]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1x      <= 43'(t1x >>> 17);
            r_p1y      <= 43'(t1y >>> 17);
            r_p2x      <= 43'(t2x >>> 17);
            r_p2y      <= 43'(t2y >>> 17);
            r_offx     <= off_x;
            r_offy     <= off_y;
            r_o_height <= md.height;
        end
    end

    // Saturated corners
    logic [31:0] r_c0x, r_c0y, r_c1x, r_c1y, r_c2x, r_c2y, r_c3x, r_c3y;
    logic [31:0] r_c_height;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0x      <= sat32(44'(r_p1x) + 44'(r_offx));
            r_c0y      <= sat32(44'(r_p1y) + 44'(r_offy));
            r_c1x      <= sat32(44'(r_p1x) - 44'(r_offx));
            r_c1y      <= sat32(44'(r_p1y) - 44'(r_offy));
            r_c2x      <= sat32(44'(r_p2x) - 44'(r_offx));
            r_c2y      <= sat32(44'(r_p2y) - 44'(r_offy));
            r_c3x      <= sat32(44'(r_p2x) + 44'(r_offx));
            r_c3y      <= sat32(44'(r_p2y) + 44'(r_offy));
            r_c_height <= r_o_height;
        end
    end

    // Short side vector, turned into the right half plane
    logic signed [32:0] xd, yd;
    logic signed [33:0] vx, vy;
    logic signed [41:0] r_tx, r_ty;
    t_fin               r_fin [0:FIN_N-1];

    always_comb begin
        xd = $signed({r_c1x[31], r_c1x}) - $signed({r_c0x[31], r_c0x});
        yd = $signed({r_c0y[31], r_c0y}) - $signed({r_c1y[31], r_c1y});
        vx = xd[32] ? -34'(xd) : 34'(xd);
        vy = xd[32] ? -34'(yd) : 34'(yd);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx            <= 42'(vx);
            r_ty            <= 42'(vy);
            r_fin[0].c0x    <= r_c0x;
            r_fin[0].c0y    <= r_c0y;
            r_fin[0].c1x    <= r_c1x;
            r_fin[0].c1y    <= r_c1y;
            r_fin[0].c2x    <= r_c2x;
            r_fin[0].c2y    <= r_c2y;
            r_fin[0].c3x    <= r_c3x;
            r_fin[0].c3y    <= r_c3y;
            r_fin[0].height <= r_c_height;
            r_fin[0].level  <= (yd <= LEVEL_LIMIT) && (yd >= -LEVEL_LIMIT);
            r_fin[0].vert   <= (r_c1x == r_c0x);
            for (int k = 1; k < FIN_N; k++) begin
                r_fin[k] <= r_fin[k-1];
            end
        end
    end

    // Normalization: largest power-of-two scale that keeps both below 2^40 in magnitude
    logic signed [41:0] s_nx [0:NORM_STEPS];
    logic signed [41:0] s_ny [0:NORM_STEPS];

    assign s_nx[0] = r_tx;
    assign s_ny[0] = r_ty;

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        lrr_norm_cell #(.SHIFT(32 >> g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (s_nx[g]),
            .i_y   (s_ny[g]),
            .o_x   (s_nx[g+1]),
            .o_y   (s_ny[g+1])
        );
    end

    // The last doubling crosses the limit.
    logic signed [44:0] s_cx [0:N];
    logic signed [44:0] s_cy [0:N];
    logic signed [32:0] s_cz [0:N];
    logic signed [44:0] r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx <= 45'(s_nx[NORM_STEPS]) <<< 1;
            r_fy <= 45'(s_ny[NORM_STEPS]) <<< 1;
        end
    end

    assign s_cx[0] = r_fx;
    assign s_cy[0] = r_fy;
    assign s_cz[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cordic
        lrr_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (s_cx[g]),
            .i_y   (s_cy[g]),
            .i_z   (s_cz[g]),
            .o_x   (s_cx[g+1]),
            .o_y   (s_cy[g+1]),
            .o_z   (s_cz[g+1])
        );
    end

    // Angle rounding, clamping and the special cases
    t_fin               fd;
    logic signed [32:0] zr;
    logic signed [18:0] ang_r, ang;
    t_fin               r_out;
    logic [17:0]        r_angle;

    always_comb begin
        fd    = r_fin[FIN_N-1];
        zr    = s_cz[N] + 33'sd8192;
        ang_r = 19'(zr >>> 14);
        if (fd.level)                    ang = '0;
        else if (fd.vert)                ang = -HALF_PI_Q16;
        else if (ang_r > HALF_PI_Q16)    ang = HALF_PI_Q16;
        else if (ang_r < -HALF_PI_Q16)   ang = -HALF_PI_Q16;
        else                             ang = ang_r;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out   <= fd;
            r_angle <= ang[17:0];
        end
    end

    assign o_corner0_x     = r_out.c0x;
    assign o_corner0_y     = r_out.c0y;
    assign o_corner1_x     = r_out.c1x;
    assign o_corner1_y     = r_out.c1y;
    assign o_corner2_x     = r_out.c2x;
    assign o_corner2_y     = r_out.c2y;
    assign o_corner3_x     = r_out.c3x;
    assign o_corner3_y     = r_out.c3y;
    assign o_region_height = r_out.height;
    assign o_region_angle  = r_angle;

    // A finished root step leaves a remainder no larger than twice the root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_SQRT] |-> (s_rem[SQRT_STEPS] <= {2'b00, s_root[SQRT_STEPS], 1'b0}))
        else $error("square root remainder out of range");

    // Both divider lanes end with a remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_DIV] |-> ((s_drem_x[DIV_STEPS] < {1'b0, s_ddiv_x[DIV_STEPS]})
                        && (s_drem_y[DIV_STEPS] < {1'b0, s_ddiv_y[DIV_STEPS]})))
        else $error("divider remainder not below divisor");

    // A level short side always gives a zero angle.
    a_level_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_corner0_y == o_corner1_y)) |-> (o_region_angle == '0))
        else $error("level short side with nonzero angle");

    // The angle never leaves plus or minus half pi.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_region_angle) <= 18'sd102944)
                      && ($signed(o_region_angle) >= -18'sd102944)))
        else $error("angle out of range");

endmodule
`default_nettype wire

// ----- rtl/core/lrr_sqrt_cell.sv -----
// One digit step of the pipelined square root.
`default_nettype none
module lrr_sqrt_cell import lrr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [65:0] i_rad,
    input  wire logic [35:0] i_rem,
    input  wire logic [32:0] i_root,
    output logic [65:0]      o_rad,
    output logic [35:0]      o_rem,
    output logic [32:0]      o_root
);
    logic [35:0] n_cur;
    logic [35:0] n_trial;
    logic [35:0] n_rem;
    logic [32:0] n_root;

    always_comb begin
        n_cur   = {i_rem[33:0], i_rad[65:64]};
        n_trial = {1'b0, i_root, 2'b01};
        if (n_cur >= n_trial) begin
            n_rem  = n_cur - n_trial;
            n_root = {i_root[31:0], 1'b1};
        end else begin
            n_rem  = n_cur;
            n_root = {i_root[31:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[63:0], 2'b00};
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lrr_div_cell.sv -----
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module lrr_div_cell import lrr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [32:0] i_num,
    input  wire logic [35:0] i_rem,
    input  wire logic [34:0] i_div,
    input  wire logic [32:0] i_quo,
    output logic [32:0]      o_num,
    output logic [35:0]      o_rem,
    output logic [34:0]      o_div,
    output logic [32:0]      o_quo
);
    logic [35:0] n_cur;
    logic [35:0] n_rem;
    logic        n_bit;

    always_comb begin
        n_cur = {i_rem[34:0], i_num[32]};
        n_bit = (n_cur >= {1'b0, i_div});
        n_rem = n_bit ? (n_cur - {1'b0, i_div}) : n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[31:0], 1'b0};
            o_rem <= n_rem;
            o_div <= i_div;
            o_quo <= {i_quo[31:0], n_bit};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lrr_norm_cell.sv -----
// One binary step of the vector normalization ahead of the angle unit.
`default_nettype none
module lrr_norm_cell import lrr_pkg::*; #(
    parameter int SHIFT = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [41:0] i_x,
    input  wire logic signed [41:0] i_y,
    output logic signed [41:0]      o_x,
    output logic signed [41:0]      o_y
);
    localparam logic signed [73:0] LIMIT = 74'sd1 <<< 40;

    logic signed [73:0] n_xs;
    logic signed [73:0] n_ys;
    logic               n_ok;

    always_comb begin
        n_xs = 74'(i_x) <<< SHIFT;
        n_ys = 74'(i_y) <<< SHIFT;
        n_ok = (n_xs < LIMIT) && (n_ys < LIMIT) && (n_ys > -LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_ok ? n_xs[41:0] : i_x;
            o_y <= n_ok ? n_ys[41:0] : i_y;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lrr_cordic_cell.sv -----
// One vectoring rotation of the arctangent unit.
`default_nettype none
module lrr_cordic_cell import lrr_pkg::*; #(
    parameter int STEP = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [44:0] i_x,
    input  wire logic signed [44:0] i_y,
    input  wire logic signed [32:0] i_z,
    output logic signed [44:0]      o_x,
    output logic signed [44:0]      o_y,
    output logic signed [32:0]      o_z
);
    localparam logic signed [32:0] ATAN = $signed({1'b0, atan_q30(STEP)});

    logic signed [44:0] n_xs;
    logic signed [44:0] n_ys;

    always_comb begin
        n_xs = i_x >>> STEP;
        n_ys = i_y >>> STEP;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[44]) begin
                o_x <= i_x + n_ys;
                o_y <= i_y - n_xs;
                o_z <= i_z + ATAN;
            end else begin
                o_x <= i_x - n_ys;
                o_y <= i_y + n_xs;
                o_z <= i_z - ATAN;
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/tb_line_region_rectangle.sv -----
// Self-checking testbench for the line region rectangle block.
`timescale 1ns / 1ps
module tb_line_region_rectangle;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 120;

    typedef struct packed {
        logic [31:0] c0x;
        logic [31:0] c0y;
        logic [31:0] c1x;
        logic [31:0] c1y;
        logic [31:0] c2x;
        logic [31:0] c2y;
        logic [31:0] c3x;
        logic [31:0] c3y;
        logic [31:0] height;
        logic [17:0] angle;
    } t_rect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = lrr_pkg::REG_REGION_WIDTH;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_start_x = '0;
    logic [31:0] i_start_y = '0;
    logic [31:0] i_end_x = '0;
    logic [31:0] i_end_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_rect       got;

    line_region_rectangle dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_corner0_x(got.c0x), .o_corner0_y(got.c0y),
        .o_corner1_x(got.c1x), .o_corner1_y(got.c1y),
        .o_corner2_x(got.c2x), .o_corner2_y(got.c2y),
        .o_corner3_x(got.c3x), .o_corner3_y(got.c3y),
        .o_region_height(got.height), .o_region_angle(got.angle)
    );

    // Predictor copy of the configuration.
    logic [31:0] width_q16 = 32'd655360;
    logic [23:0] ratio_q8 = 24'd65536;

    t_rect pending_rects[$];
    int    error_count = 0;
    int    segments_sent = 0;
    int    rects_checked = 0;
    int    cycle_count = 0;
    bit    calm = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Rounded square root of a 66 bit value, one digit pair per step.
    function automatic longint unsigned rounded_root(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'(v[2*k+1 -: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        if (rem > root) root = root + 1;
        return root[63:0];
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // CORDIC vectoring of (x, y) with sixteen rotations, result in Q2.16.
    function automatic longint short_side_angle(input longint x, input longint y);
        longint z;
        longint nx;
        longint ny;
        longint r;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        while (x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40) && y > -(64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + longint'(lrr_pkg::atan_q30(i));
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - longint'(lrr_pkg::atan_q30(i));
            end
            x = nx;
            y = ny;
        end
        r = (z + 8192) >>> 14;
        if (r > 102944) r = 102944;
        if (r < -102944) r = -102944;
        return r;
    endfunction

    function automatic t_rect predict_rect(input logic [31:0] sx, input logic [31:0] sy,
                                           input logic [31:0] ex, input logic [31:0] ey);
        longint x1, y1, x2, y2, dx, dy, ux, uy;
        longint offx, offy, rx, ry, p1x, p1y, p2x, p2y, ydiff, ang;
        longint c[8];
        logic [65:0] ux66, uy66;
        logic [71:0] px, py, two;
        longint unsigned len, hgt;
        t_rect r;
        x1 = longint'(signed'(sx));
        y1 = longint'(signed'(sy));
        x2 = longint'(signed'(ex));
        y2 = longint'(signed'(ey));
        dx = x1 - x2;
        dy = y1 - y2;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        ux66 = 66'(ux);
        uy66 = 66'(uy);
        len = rounded_root(ux66 * ux66 + uy66 * uy66);
        hgt = (len * 64'(ratio_q8) + 64'd32768) >> 16;
        if (hgt > 64'hFFFFFFFF) hgt = 64'hFFFFFFFF;
        if (dx == 0) begin
            offx = (longint'(width_q16) + 1) >>> 1;
            offy = 0;
        end else begin
            two = 72'(len) * 2;
            px = (72'(uy) * 72'(width_q16) + 72'(len)) / two;
            py = (72'(ux) * 72'(width_q16) + 72'(len)) / two;
            offx = (((dx > 0) == (dy >= 0)) || dy == 0) ? longint'(px) : -longint'(px);
            offy = -longint'(py);
        end
        rx = longint'(ratio_q8) * dx;
        ry = longint'(ratio_q8) * dy;
        p1x = ((x1 + x2) * 65536 + rx + 65536) >>> 17;
        p1y = ((y1 + y2) * 65536 + ry + 65536) >>> 17;
        p2x = ((x1 + x2) * 65536 - rx + 65536) >>> 17;
        p2y = ((y1 + y2) * 65536 - ry + 65536) >>> 17;
        c[0] = clamp32(p1x + offx);
        c[1] = clamp32(p1y + offy);
        c[2] = clamp32(p1x - offx);
        c[3] = clamp32(p1y - offy);
        c[4] = clamp32(p2x - offx);
        c[5] = clamp32(p2y - offy);
        c[6] = clamp32(p2x + offx);
        c[7] = clamp32(p2y + offy);
        ydiff = c[3] - c[1];
        if (ydiff <= 6 && ydiff >= -6) ang = 0;
        else if (c[2] == c[0]) ang = -102944;
        else ang = short_side_angle(c[2] - c[0], c[1] - c[3]);
        r.c0x = c[0][31:0];
        r.c0y = c[1][31:0];
        r.c1x = c[2][31:0];
        r.c1y = c[3][31:0];
        r.c2x = c[4][31:0];
        r.c2y = c[5][31:0];
        r.c3x = c[6][31:0];
        r.c3y = c[7][31:0];
        r.height = hgt[31:0];
        r.angle = ang[17:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Result checker: samples at the falling edge, where the handshake is settled.
    initial begin
        t_rect want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_rects.size() == 0) begin
                    $error("result item with no expectation waiting");
                    error_count++;
                end else begin
                    want = pending_rects.pop_front();
                    check_field("corner0_x", want.c0x, got.c0x);
                    check_field("corner0_y", want.c0y, got.c0y);
                    check_field("corner1_x", want.c1x, got.c1x);
                    check_field("corner1_y", want.c1y, got.c1y);
                    check_field("corner2_x", want.c2x, got.c2x);
                    check_field("corner2_y", want.c2y, got.c2y);
                    check_field("corner3_x", want.c3x, got.c3x);
                    check_field("corner3_y", want.c3y, got.c3y);
                    check_field("region_height", want.height, got.height);
                    check_field("region_angle", 32'(want.angle), 32'(got.angle));
                    rects_checked++;
                end
            end
        end
    end

    // Receiver stalls in random bursts.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 12) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_segment(input logic [31:0] sx, input logic [31:0] sy,
                                input logic [31:0] ex, input logic [31:0] ey);
        bit taken;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            if (taken) pending_rects.push_back(predict_rect(sx, sy, ex, ey));
            @(posedge i_clk);
        end while (!taken);
        segments_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rects.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input lrr_pkg::t_cfg_reg idx, input logic [31:0] value);
        bit taken;
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        if (idx == lrr_pkg::REG_REGION_WIDTH) width_q16 = value;
        else ratio_q8 = value[23:0];
        @(posedge i_clk);
    endtask

    task automatic random_segment();
        logic [31:0] sx, sy, ex, ey;
        logic [31:0] picks[5];
        picks = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
        sx = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        sy = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        ex = sx + $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
        ey = sy + $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
        case ($urandom_range(0, 9))
            0: ex = sx;
            1: ey = sy;
            2: begin
                ex = sx;
                ey = sy;
            end
            6, 7: begin
                sx = $urandom;
                sy = $urandom;
                ex = $urandom;
                ey = $urandom;
            end
            8: begin
                sx = picks[$urandom_range(0, 4)];
                sy = picks[$urandom_range(0, 4)];
                ex = picks[$urandom_range(0, 4)];
                ey = picks[$urandom_range(0, 4)];
            end
            9: ex = sx + $urandom_range(0, 16) - 8;
            default: ;
        endcase
        send_segment(sx, sy, ex, ey);
    endtask

    task automatic test_extremes();
        send_segment(32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_segment(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_segment(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_segment(32'h0003_0000, 32'h0004_0000, 32'hFFFD_0000, 32'hFFFC_0000);
        send_segment(32'hFFFD_0000, 32'h0004_0000, 32'h0003_0000, 32'hFFFC_0000);
    endtask

    task automatic test_special_cases();
        // Vertical, degenerate and horizontal segments, then nearly vertical and nearly horizontal ones.
        send_segment(32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'h0009_0000);
        send_segment(32'h0005_0000, 32'h0009_0000, 32'h0005_0000, 32'h0001_0000);
        send_segment(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0);
        send_segment(32'h0001_0000, 32'h0002_0000, 32'h0009_0000, 32'h0002_0000);
        send_segment(32'h0009_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        send_segment(32'h0, 32'h0, 32'h0000_0001, 32'h0010_0000);
        send_segment(32'h0, 32'h0, 32'h0000_0002, 32'h7FFF_0000);
        send_segment(32'h0, 32'h0, 32'h0100_0000, 32'h0000_0003);
    endtask

    task automatic test_config_extremes();
        write_register(lrr_pkg::REG_REGION_WIDTH, 32'h0);
        write_register(lrr_pkg::REG_LENGTH_RATIO, 32'hFF00_0000);
        send_segment(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0005_0000);
        send_segment(32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'h0009_0000);
        write_register(lrr_pkg::REG_REGION_WIDTH, 32'hFFFF_FFFF);
        write_register(lrr_pkg::REG_LENGTH_RATIO, 32'h00FF_FFFF);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'h0009_0000);
        send_segment(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0005_0000);
    endtask

    task automatic test_random_sweep();
        logic [31:0] widths[6];
        logic [31:0] ratios[6];
        widths = '{32'd655360, 32'h0, 32'hFFFF_FFFF, 32'd131072, 32'h0, 32'h0};
        ratios = '{32'd65536, 32'h0, 32'd65536, 32'h00FF_FFFF, 32'h0, 32'h0};
        widths[4] = $urandom;
        ratios[4] = $urandom;
        widths[5] = $urandom_range(0, 32'h00FF_FFFF);
        ratios[5] = $urandom_range(0, 32'h0003_FFFF);
        for (int p = 0; p < 6; p++) begin
            write_register(lrr_pkg::REG_REGION_WIDTH, widths[p]);
            write_register(lrr_pkg::REG_LENGTH_RATIO, ratios[p]);
            for (int n = 0; n < 115; n++) begin
                if (p == 5 && n == 50) calm = 1'b1;
                // Let the pipeline run empty once in the middle of a phase.
                if (p == 2 && n == 60) drain_results();
                random_segment();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special_cases();
        test_config_extremes();
        test_random_sweep();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d segments over six width and ratio settings, %0d results checked.",
                 segments_sent, rects_checked);
        if (error_count == 0 && pending_rects.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
